FILE: hdl/dmvp_pkg.sv
// dmvp_pkg: shared widths, constants and types of the dual motor velocity pid
// used by dmvp_div, dmvp_lane, dmvp_assertions and dual_motor_velocity_pid
// no dependencies
package dmvp_pkg;

  // field widths
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SPD_W   = 16;
  localparam int unsigned TIME_W  = 20;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // full scale rate in counts per second
  localparam int unsigned FSR_DEFAULT = 1000;

  // reset gains, Q8.16
  localparam logic signed [GAIN_W-1:0] PROP_RESET  = 24'sd32768;
  localparam logic signed [GAIN_W-1:0] INTEG_RESET = 24'sd6554;
  localparam logic signed [GAIN_W-1:0] DERIV_RESET = 24'sd3277;

  // divider geometry
  localparam int unsigned DIV_NUM_W = 60;
  localparam int unsigned DIV_DEN_W = 20;
  localparam int unsigned DIV_RADIX = 2;

  // scale constants
  localparam int unsigned VEL_SCALE_W = 28;
  localparam logic [VEL_SCALE_W-1:0] VEL_SCALE = 28'd256000000;
  localparam logic [DIV_DEN_W-1:0]   MICRO     = 20'd1000000;
  localparam int unsigned TGT_SHIFT = 7;

  // datapath widths
  localparam int unsigned ERR_W   = 32;
  localparam int unsigned INTEG_W = 48;
  localparam int unsigned SUM_W   = 57;
  localparam int unsigned HALF_W  = 27;
  localparam int unsigned PP_W    = GAIN_W + HALF_W;
  localparam int unsigned PROD_W  = 78;
  localparam int unsigned OPND_W  = 2 * HALF_W;
  localparam int unsigned TERM_W  = 54;
  localparam logic [PROD_W-1:0] PROD_LIMIT = 78'h1 << 62;
  localparam int unsigned PD_SHIFT = 9;
  localparam int unsigned I_SHIFT  = 17;
  localparam logic signed [SUM_W-1:0] DRIVE_MAX = 57'sd32768;
  localparam logic signed [SUM_W-1:0] DRIVE_MIN = -57'sd32768;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP  = 2'd0,
    CFG_INTEG = 2'd1,
    CFG_DERIV = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop;
    logic signed [GAIN_W-1:0] integ;
    logic signed [GAIN_W-1:0] deriv;
  } gains_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic              forward;
    logic [DUTY_W-1:0] duty;
  } lane_res_t;

endpackage

FILE: hdl/dual_motor_velocity_pid.sv
// dual_motor_velocity_pid: top level, gain registers, two motor lanes
// and the merging output register; uses dmvp_pkg and dmvp_lane
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   left/right_count, left/right_speed, elapsed_us
//  out      output     out_valid_o / out_stall_i left/right_forward, left/right_duty
//  cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// the time from acceptance to a valid result is set by the three divisions
// (30 radix-4 steps each) per lane
// both lanes run in step; one transaction is in work at a time, and the next
// is taken as soon as the previous result moves into the output register
// reset clears the gains to their defaults and the integral and error history
// a stalled output holds the finished lanes, which then hold the input stall
module dual_motor_velocity_pid #(
  parameter int unsigned FULL_SCALE_RATE = dmvp_pkg::FSR_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [dmvp_pkg::CNT_W-1:0]      left_count_i,
  input  logic signed [dmvp_pkg::CNT_W-1:0]      right_count_i,
  input  logic signed [dmvp_pkg::SPD_W-1:0]      left_speed_i,
  input  logic signed [dmvp_pkg::SPD_W-1:0]      right_speed_i,
  input  logic        [dmvp_pkg::TIME_W-1:0]     elapsed_us_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   left_forward_o,
  output logic        [dmvp_pkg::DUTY_W-1:0]     left_duty_o,
  output logic                                   right_forward_o,
  output logic        [dmvp_pkg::DUTY_W-1:0]     right_duty_o,
  input  logic                                   cfg_we_i,
  input  logic        [dmvp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [dmvp_pkg::GAIN_W-1:0]     cfg_data_i
);

  dmvp_pkg::gains_t     gains_q;
  dmvp_pkg::lane_ctrl_t ctrl;
  dmvp_pkg::lane_res_t  left_res, right_res, left_q, right_q;
  logic busy_q, out_valid_q;
  logic left_done, right_done, accept;
  logic [dmvp_pkg::TIME_W-1:0] time_fix;

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.prop  <= dmvp_pkg::PROP_RESET;
      gains_q.integ <= dmvp_pkg::INTEG_RESET;
      gains_q.deriv <= dmvp_pkg::DERIV_RESET;
    end else if (cfg_we_i) begin
      case (dmvp_pkg::cfg_idx_e'(cfg_idx_i))
        dmvp_pkg::CFG_PROP:  gains_q.prop  <= $signed(cfg_data_i);
        dmvp_pkg::CFG_INTEG: gains_q.integ <= $signed(cfg_data_i);
        dmvp_pkg::CFG_DERIV: gains_q.deriv <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // zero elapsed time counts as one microsecond
  assign time_fix = (elapsed_us_i == '0) ? dmvp_pkg::TIME_W'(1) : elapsed_us_i;

  assign accept     = in_valid_i && !busy_q;
  assign ctrl.start = accept;
  assign ctrl.ack   = left_done && right_done && (!out_valid_q || !out_stall_i);

  dmvp_lane #(.FULL_SCALE_RATE(FULL_SCALE_RATE)) u_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .gains_i(gains_q),
    .count_i(left_count_i),
    .speed_i(left_speed_i),
    .time_i (time_fix),
    .done_o (left_done),
    .res_o  (left_res)
  );

  dmvp_lane #(.FULL_SCALE_RATE(FULL_SCALE_RATE)) u_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .gains_i(gains_q),
    .count_i(right_count_i),
    .speed_i(right_speed_i),
    .time_i (time_fix),
    .done_o (right_done),
    .res_o  (right_res)
  );

  // merge both lanes into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (ctrl.ack) begin
        busy_q <= 1'b0;
      end
      if (ctrl.ack) begin
        out_valid_q <= 1'b1;
        left_q      <= left_res;
        right_q     <= right_res;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o      = busy_q;
  assign out_valid_o     = out_valid_q;
  assign left_forward_o  = left_q.forward;
  assign left_duty_o     = left_q.duty;
  assign right_forward_o = right_q.forward;
  assign right_duty_o    = right_q.duty;

endmodule

FILE: hdl/dmvp_div.sv
// dmvp_div: unsigned restoring divider, two quotient bits per cycle
// uses dmvp_pkg for its widths
// one start gives a done pulse and a held quotient after the last step
module dmvp_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dmvp_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [dmvp_pkg::DIV_DEN_W-1:0] den_i,
  output logic                           done_o,
  output logic [dmvp_pkg::DIV_NUM_W-1:0] quo_o
);

  localparam int unsigned NumW  = dmvp_pkg::DIV_NUM_W;
  localparam int unsigned DenW  = dmvp_pkg::DIV_DEN_W;
  localparam int unsigned Steps = dmvp_pkg::DIV_NUM_W / dmvp_pkg::DIV_RADIX;
  localparam int unsigned CntW  = $clog2(Steps);
  localparam logic [CntW-1:0] LastCnt = CntW'(Steps - 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] rem_q, rem_d, den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;

  // radix steps of shift and conditional subtract
  always_comb begin
    logic [DenW:0] trial;
    num_d = num_q;
    rem_d = rem_q;
    for (int k = 0; k < dmvp_pkg::DIV_RADIX; k++) begin
      trial = {rem_d, num_d[NumW-1]};
      num_d = {num_d[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        num_d[0] = 1'b1;
      end
      rem_d = trial[DenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
      end else if (busy_q) begin
        num_q <= num_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

FILE: hdl/dmvp_lane.sv
// dmvp_lane: pid core of one motor, sequenced over a single divider
// and a 24x27 multiplier; uses dmvp_pkg and dmvp_div
// holds the integral and previous error of its motor
module dmvp_lane #(
  parameter int unsigned FULL_SCALE_RATE = dmvp_pkg::FSR_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dmvp_pkg::lane_ctrl_t                ctrl_i,
  input  dmvp_pkg::gains_t                    gains_i,
  input  logic signed [dmvp_pkg::CNT_W-1:0]   count_i,
  input  logic signed [dmvp_pkg::SPD_W-1:0]   speed_i,
  input  logic        [dmvp_pkg::TIME_W-1:0]  time_i,
  output logic                                done_o,
  output dmvp_pkg::lane_res_t                 res_o
);

  localparam int unsigned NumW  = dmvp_pkg::DIV_NUM_W;
  localparam int unsigned ErrW  = dmvp_pkg::ERR_W;
  localparam int unsigned IntW  = dmvp_pkg::INTEG_W;
  localparam int unsigned SumW  = dmvp_pkg::SUM_W;
  localparam int unsigned HalfW = dmvp_pkg::HALF_W;
  localparam int unsigned PpW   = dmvp_pkg::PP_W;
  localparam int unsigned ProdW = dmvp_pkg::PROD_W;
  localparam int unsigned OpW   = dmvp_pkg::OPND_W;
  localparam int unsigned TermW = dmvp_pkg::TERM_W;
  localparam int unsigned TimeW = dmvp_pkg::TIME_W;
  localparam int unsigned GainW = dmvp_pkg::GAIN_W;

  typedef enum logic [3:0] {
    L_IDLE, L_VEL, L_INC_GO, L_INC, L_DER_GO, L_DER, L_GAIN, L_FIN, L_DONE
  } lane_state_e;

  typedef enum logic [1:0] {
    GAIN_P, GAIN_I, GAIN_D
  } gain_sel_e;

  lane_state_e state_q;
  gain_sel_e   sel_q;
  logic        half_q;

  logic signed [dmvp_pkg::SPD_W-1:0] speed_q;
  logic signed [25:0]                tgt_q;
  logic        [TimeW-1:0]           time_q;
  logic                              csign_q;
  logic signed [ErrW-1:0]            e_q, prev_q;
  logic signed [ErrW:0]              diff_q;
  logic signed [IntW-1:0]            integ_q;
  logic        [52:0]                dmag_q;
  logic                              dsign_q;
  logic        [PpW-1:0]             acc_q;
  logic signed [SumW-1:0]            sum_q;
  dmvp_pkg::lane_res_t               res_q;

  logic                              div_start, div_done;
  logic [NumW-1:0]                   div_num, div_quo;
  logic [dmvp_pkg::DIV_DEN_W-1:0]    div_den;

  // magnitudes of the incoming fields
  logic [15:0] cmag, smag;
  logic [31:0] sprod;
  logic [24:0] tgt_mag;
  logic signed [25:0] tgt_d;
  assign cmag    = count_i[15] ? 16'(-count_i) : 16'(count_i);
  assign smag    = speed_i[15] ? 16'(-speed_i) : 16'(speed_i);
  assign sprod   = 32'(smag) * 32'(FULL_SCALE_RATE);
  assign tgt_mag = sprod[31:dmvp_pkg::TGT_SHIFT];
  assign tgt_d   = speed_i[15] ? -$signed({1'b0, tgt_mag}) : $signed({1'b0, tgt_mag});

  // magnitudes of stored values
  logic [ErrW-1:0] emag;
  logic [ErrW:0]   diffmag;
  logic [IntW-1:0] imag;
  assign emag    = e_q[ErrW-1] ? ErrW'(-e_q) : ErrW'(e_q);
  assign diffmag = diff_q[ErrW] ? (ErrW+1)'(-diff_q) : (ErrW+1)'(diff_q);
  assign imag    = integ_q[IntW-1] ? IntW'(-integ_q) : IntW'(integ_q);

  // divider operands
  logic [43:0] vprod;
  logic [50:0] eprod;
  logic [52:0] dprod;
  assign vprod = 44'(cmag) * 44'(dmvp_pkg::VEL_SCALE);
  assign eprod = 51'(emag) * 51'(time_q);
  assign dprod = 53'(diffmag) * 53'(dmvp_pkg::MICRO);

  always_comb begin
    unique case (state_q)
      L_INC_GO: begin
        div_num = NumW'({eprod, 8'b0});
        div_den = dmvp_pkg::MICRO;
      end
      L_DER_GO: begin
        div_num = NumW'(dprod);
        div_den = time_q;
      end
      default: begin
        div_num = NumW'(vprod);
        div_den = (state_q == L_IDLE) ? time_i : time_q;
      end
    endcase
  end
  assign div_start = (state_q == L_IDLE && ctrl_i.start) ||
                     state_q == L_INC_GO || state_q == L_DER_GO;

  dmvp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // velocity and saturated error
  logic [43:0]        vel_mag;
  logic signed [44:0] vel;
  logic signed [45:0] err_raw;
  logic signed [ErrW-1:0] err_sat;
  logic err_ovf;
  assign vel_mag = div_quo[43:0];
  assign vel     = csign_q ? -$signed({1'b0, vel_mag}) : $signed({1'b0, vel_mag});
  assign err_raw = 46'(tgt_q) - 46'(vel);
  assign err_ovf = !(&err_raw[45:ErrW-1]) && (|err_raw[45:ErrW-1]);
  assign err_sat = err_ovf ? (err_raw[45] ? {1'b1, {(ErrW-1){1'b0}}}
                                          : {1'b0, {(ErrW-1){1'b1}}})
                           : err_raw[ErrW-1:0];

  // integral increment and saturated accumulate
  logic [40:0]          inc_mag;
  logic signed [41:0]   inc;
  logic signed [IntW:0] isum;
  logic signed [IntW-1:0] integ_sat;
  assign inc_mag   = div_quo[40:0];
  assign inc       = e_q[ErrW-1] ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
  assign isum      = (IntW+1)'(integ_q) + (IntW+1)'(inc);
  assign integ_sat = (isum[IntW] != isum[IntW-1])
                   ? (isum[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}})
                   : isum[IntW-1:0];

  // gain term: operand selection and partial product
  logic signed [GainW-1:0] gsig;
  logic [GainW-1:0]        gmag;
  logic [OpW-1:0]          omag;
  logic                    osign;
  always_comb begin
    unique case (sel_q)
      GAIN_P: begin
        gsig  = gains_i.prop;
        omag  = OpW'(emag);
        osign = e_q[ErrW-1];
      end
      GAIN_I: begin
        gsig  = gains_i.integ;
        omag  = OpW'(imag);
        osign = integ_q[IntW-1];
      end
      default: begin
        gsig  = gains_i.deriv;
        omag  = OpW'(dmag_q);
        osign = dsign_q;
      end
    endcase
  end
  assign gmag = gsig[GainW-1] ? GainW'(-gsig) : GainW'(gsig);

  logic [HalfW-1:0]  ohalf;
  logic [PpW-1:0]    pp;
  logic [ProdW-1:0]  full, clamp, shifted;
  logic [TermW-1:0]  tmag;
  logic signed [SumW-1:0] term;
  assign ohalf   = half_q ? omag[OpW-1:HalfW] : omag[HalfW-1:0];
  assign pp      = PpW'(gmag) * PpW'(ohalf);
  assign full    = ProdW'(acc_q) + (ProdW'(pp) << HalfW);
  assign clamp   = (full > dmvp_pkg::PROD_LIMIT) ? dmvp_pkg::PROD_LIMIT : full;
  assign shifted = (sel_q == GAIN_I) ? (clamp >> dmvp_pkg::I_SHIFT)
                                     : (clamp >> dmvp_pkg::PD_SHIFT);
  assign tmag    = shifted[TermW-1:0];
  assign term    = (gsig[GainW-1] ^ osign) ? -$signed(SumW'(tmag)) : $signed(SumW'(tmag));

  // drive saturation and split into direction and magnitude
  logic signed [SumW-1:0] neg_sum;
  logic [dmvp_pkg::DUTY_W-1:0] duty_d;
  assign neg_sum = -sum_q;
  always_comb begin
    if (!sum_q[SumW-1]) begin
      duty_d = (sum_q > dmvp_pkg::DRIVE_MAX) ? 16'h8000 : sum_q[15:0];
    end else begin
      duty_d = (sum_q < dmvp_pkg::DRIVE_MIN) ? 16'h8000 : neg_sum[15:0];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      sel_q   <= GAIN_P;
      half_q  <= 1'b0;
      speed_q <= '0;
      tgt_q   <= '0;
      time_q  <= '0;
      csign_q <= 1'b0;
      e_q     <= '0;
      prev_q  <= '0;
      diff_q  <= '0;
      integ_q <= '0;
      dmag_q  <= '0;
      dsign_q <= 1'b0;
      acc_q   <= '0;
      sum_q   <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        L_IDLE: begin
          if (ctrl_i.start) begin
            speed_q <= speed_i;
            tgt_q   <= tgt_d;
            time_q  <= time_i;
            csign_q <= count_i[15];
            state_q <= L_VEL;
          end
        end
        L_VEL: begin
          if (div_done) begin
            e_q     <= err_sat;
            state_q <= L_INC_GO;
          end
        end
        L_INC_GO: state_q <= L_INC;
        L_INC: begin
          if (div_done) begin
            integ_q <= integ_sat;
            diff_q  <= (ErrW+1)'(e_q) - (ErrW+1)'(prev_q);
            prev_q  <= e_q;
            state_q <= L_DER_GO;
          end
        end
        L_DER_GO: state_q <= L_DER;
        L_DER: begin
          if (div_done) begin
            dmag_q  <= div_quo[52:0];
            dsign_q <= diff_q[ErrW];
            sum_q   <= SumW'(speed_q);
            sel_q   <= GAIN_P;
            half_q  <= 1'b0;
            state_q <= L_GAIN;
          end
        end
        L_GAIN: begin
          // low half into the accumulator, then high half and the term
          if (!half_q) begin
            acc_q  <= pp;
            half_q <= 1'b1;
          end else begin
            sum_q  <= sum_q + term;
            half_q <= 1'b0;
            unique case (sel_q)
              GAIN_P:  sel_q <= GAIN_I;
              GAIN_I:  sel_q <= GAIN_D;
              default: state_q <= L_FIN;
            endcase
          end
        end
        L_FIN: begin
          res_q.forward <= !sum_q[SumW-1];
          res_q.duty    <= duty_d;
          state_q       <= L_DONE;
        end
        L_DONE: begin
          if (ctrl_i.ack) begin
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == L_DONE);
  assign res_o  = res_q;

endmodule

FILE: hdl/dmvp_checker.sv
// dmvp_assertions: port-level assertions of dual_motor_velocity_pid
// uses dmvp_pkg; bound to the top level at the end of this file
module dmvp_assertions (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic                                   left_forward_o,
  input logic        [dmvp_pkg::DUTY_W-1:0]     left_duty_o,
  input logic                                   right_forward_o,
  input logic        [dmvp_pkg::DUTY_W-1:0]     right_duty_o
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its duty values
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(left_duty_o) && $stable(right_duty_o))
    else $error("stalled result changed");

  // an accepted transaction keeps the input stalled in the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

  // duty never exceeds full scale
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_duty_o <= 16'h8000 && right_duty_o <= 16'h8000)
    else $error("duty above full scale");

  // reverse direction only with a nonzero drive
  a_reverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_forward_o || left_duty_o != '0) &&
                    (right_forward_o || right_duty_o != '0))
    else $error("reverse direction with zero duty");

endmodule

bind dual_motor_velocity_pid dmvp_assertions u_dmvp_assertions (.*);
